### rtl/chained_hash_table_engine_assert.svh
// Assertion macros for the chained hash table engine.
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH

// Condition holds on every clock edge out of reset.
`define CHT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("chained hash table engine: invariant violated");

// Consequent holds in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chained hash table engine: sequence violated");

`endif

### rtl/cht_pkg.sv
// Shared codes and controller state type for the chained hash table engine.
package cht_pkg;

    localparam logic [1:0] REQ_GET = 2'd0;
    localparam logic [1:0] REQ_SET = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;
    localparam logic [1:0] REQ_NOP = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_HEAD    = 8'b0000_0010,
        S_ENTRY   = 8'b0000_0100,
        S_RB_KEY  = 8'b0000_1000,
        S_RB_HEAD = 8'b0001_0000,
        S_RB_LINK = 8'b0010_0000,
        S_INS_RD  = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } state_t;

endpackage

### rtl/chained_hash_table_engine.sv
// Chained hash table engine: bin heads and entry pool in synchronous memories.
//
// Input channel (in_valid / in_stall) carries one request word: req_type
// (get, set, delete or no-op), key and value. Output channel (out_valid /
// out_stall) returns one result word per request: status, hit and read_value.
// The bin of a key is its low bits under the current bin mask; CAPACITY and
// INITIAL_BINS are powers of two.
// The chain walk reads one entry per cycle after the head read: a get or
// delete walks until a match or the chain end, a plain set writes the new
// entry, and a set that doubles the bins first rebuilds the chains (key
// read, head read and link write per live slot, a skip per dead slot) and
// then rereads the head. One request is worked at a time.
// The result register decouples the sides: a new word is taken while the
// previous result still waits, and a stalled result holds until taken.
// Reset empties every bin, clears the slot count and sets the initial bin
// count; the pool memories are not cleared and need no clearing pass.
module chained_hash_table_engine #(
    parameter int CAPACITY     = 256,
    parameter int INITIAL_BINS = 8,
    parameter int KEY_WIDTH    = 32,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic                   hit,
    output logic [VALUE_WIDTH-1:0] read_value
);
    import cht_pkg::*;

    localparam int SLOT_W    = $clog2(CAPACITY + 1);
    localparam int BIN_W     = $clog2(CAPACITY);
    localparam int KX_W      = (KEY_WIDTH > BIN_W) ? KEY_WIDTH : BIN_W;
    localparam int INIT_BINS = (INITIAL_BINS > CAPACITY) ? CAPACITY : INITIAL_BINS;
    localparam logic [SLOT_W-1:0] NO_SLOT   = SLOT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] BINS_INIT = SLOT_W'(INIT_BINS);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] slots_used_reg, slots_used_next;
    logic [SLOT_W-1:0] bins_reg, bins_next;
    logic [CAPACITY-1:0] head_vld_reg;
    logic [CAPACITY-1:0] live_reg;

    logic [1:0]             req_reg, req_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [BIN_W-1:0]       bin_reg, bin_next;
    logic [SLOT_W-1:0]      cur_reg, cur_next;
    logic [SLOT_W-1:0]      prev_reg, prev_next;
    logic [SLOT_W-1:0]      rb_slot_reg, rb_slot_next;
    logic [BIN_W-1:0]       rb_bin_reg, rb_bin_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic                   res_hit_reg, res_hit_next;
    logic [VALUE_WIDTH-1:0] res_value_reg, res_value_next;
    logic [1:0]             status_reg, status_next;
    logic                   hit_reg, hit_next;
    logic [VALUE_WIDTH-1:0] read_value_reg, read_value_next;

    logic [KEY_WIDTH-1:0]   key_mem  [CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
    logic [SLOT_W-1:0]      link_mem [CAPACITY];
    logic [SLOT_W-1:0]      head_mem [CAPACITY];
    logic [KEY_WIDTH-1:0]   key_q;
    logic [VALUE_WIDTH-1:0] val_q;
    logic [SLOT_W-1:0]      link_q;
    logic [SLOT_W-1:0]      head_q;
    logic                   head_vld_q;

    logic [BIN_W-1:0]  ent_ra, head_ra, ent_wa, link_wa, head_wa, live_a;
    logic              ent_we, link_we, head_we, head_clr, live_set, live_clr;
    logic [SLOT_W-1:0] link_wd, head_wd, head_eff;
    logic [BIN_W-1:0]  bin_mask, in_bin, q_bin, reg_bin;
    logic [KX_W-1:0]   in_key_x, q_key_x, reg_key_x;
    logic [SLOT_W:0]   bins_dbl;
    logic [SLOT_W-1:0] bins_grow;

    assign bin_mask  = BIN_W'(bins_reg - 1'b1);
    assign in_key_x  = KX_W'(key);
    assign q_key_x   = KX_W'(key_q);
    assign reg_key_x = KX_W'(key_reg);
    assign in_bin    = in_key_x[BIN_W-1:0] & bin_mask;
    assign q_bin     = q_key_x[BIN_W-1:0] & bin_mask;
    assign reg_bin   = reg_key_x[BIN_W-1:0] & bin_mask;
    assign bins_dbl  = {bins_reg, 1'b0};
    assign bins_grow = (bins_dbl > (SLOT_W+1)'(CAPACITY)) ? NO_SLOT : bins_dbl[SLOT_W-1:0];
    assign head_eff  = head_vld_q ? head_q : NO_SLOT;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg & out_stall;
        slots_used_next = slots_used_reg;
        bins_next       = bins_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        bin_next        = bin_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        rb_slot_next    = rb_slot_reg;
        rb_bin_next     = rb_bin_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_value_next  = res_value_reg;
        status_next     = status_reg;
        hit_next        = hit_reg;
        read_value_next = read_value_reg;
        head_ra  = in_bin;
        ent_ra   = cur_reg[BIN_W-1:0];
        ent_we   = 1'b0;
        ent_wa   = slots_used_reg[BIN_W-1:0];
        link_we  = 1'b0;
        link_wa  = slots_used_reg[BIN_W-1:0];
        link_wd  = head_eff;
        head_we  = 1'b0;
        head_wa  = bin_reg;
        head_wd  = slots_used_reg;
        head_clr = 1'b0;
        live_set = 1'b0;
        live_clr = 1'b0;
        live_a   = slots_used_reg[BIN_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    key_next   = key;
                    value_next = value;
                    bin_next   = in_bin;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                res_hit_next   = 1'b0;
                res_value_next = '0;
                prev_next      = NO_SLOT;
                cur_next       = head_eff;
                ent_ra         = head_eff[BIN_W-1:0];
                case (req_reg) inside
                    REQ_GET, REQ_DEL:
                    begin
                        if (head_eff == NO_SLOT)
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_ENTRY;
                        end
                    end
                    REQ_SET:
                    begin
                        if (slots_used_reg == NO_SLOT)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESP;
                        end
                        else if (slots_used_reg >= bins_reg && bins_reg != NO_SLOT)
                        begin
                            bins_next    = bins_grow;
                            head_clr     = 1'b1;
                            rb_slot_next = '0;
                            state_next   = S_RB_KEY;
                        end
                        else
                        begin
                            ent_we          = 1'b1;
                            link_we         = 1'b1;
                            head_we         = 1'b1;
                            live_set        = 1'b1;
                            slots_used_next = slots_used_reg + 1'b1;
                            res_status_next = ST_DONE;
                            state_next      = S_RESP;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_DONE;
                        state_next      = S_RESP;
                    end
                endcase
            end
            S_ENTRY:
            begin
                if (key_q == key_reg)
                begin
                    res_status_next = ST_DONE;
                    state_next      = S_RESP;
                    if (req_reg == REQ_GET)
                    begin
                        res_hit_next   = 1'b1;
                        res_value_next = val_q;
                    end
                    else
                    begin
                        live_clr = 1'b1;
                        live_a   = cur_reg[BIN_W-1:0];
                        if (prev_reg == NO_SLOT)
                        begin
                            head_we = 1'b1;
                            head_wd = link_q;
                        end
                        else
                        begin
                            link_we = 1'b1;
                            link_wa = prev_reg[BIN_W-1:0];
                            link_wd = link_q;
                        end
                    end
                end
                else if (link_q == NO_SLOT)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_RESP;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_q;
                    ent_ra    = link_q[BIN_W-1:0];
                end
            end
            S_RB_KEY:
            begin
                ent_ra = rb_slot_reg[BIN_W-1:0];
                if (rb_slot_reg == slots_used_reg)
                begin
                    state_next = S_INS_RD;
                end
                else if (live_reg[rb_slot_reg[BIN_W-1:0]])
                begin
                    state_next = S_RB_HEAD;
                end
                else
                begin
                    rb_slot_next = rb_slot_reg + 1'b1;
                end
            end
            S_RB_HEAD:
            begin
                head_ra     = q_bin;
                rb_bin_next = q_bin;
                state_next  = S_RB_LINK;
            end
            S_RB_LINK:
            begin
                link_we      = 1'b1;
                link_wa      = rb_slot_reg[BIN_W-1:0];
                link_wd      = head_eff;
                head_we      = 1'b1;
                head_wa      = rb_bin_reg;
                head_wd      = rb_slot_reg;
                rb_slot_next = rb_slot_reg + 1'b1;
                state_next   = S_RB_KEY;
            end
            S_INS_RD:
            begin
                head_ra    = reg_bin;
                bin_next   = reg_bin;
                state_next = S_HEAD;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    hit_next        = res_hit_reg;
                    read_value_next = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            slots_used_reg <= '0;
            bins_reg       <= BINS_INIT;
            head_vld_reg   <= '0;
            live_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            slots_used_reg <= slots_used_next;
            bins_reg       <= bins_next;
            if (head_clr)
                head_vld_reg <= '0;
            else if (head_we)
                head_vld_reg[head_wa] <= 1'b1;
            if (live_set)
                live_reg[live_a] <= 1'b1;
            else if (live_clr)
                live_reg[live_a] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        bin_reg        <= bin_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        rb_slot_reg    <= rb_slot_next;
        rb_bin_reg     <= rb_bin_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_value_reg  <= res_value_next;
        status_reg     <= status_next;
        hit_reg        <= hit_next;
        read_value_reg <= read_value_next;
        head_vld_q     <= head_vld_reg[head_ra];
    end

    // entry pool
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            key_mem[ent_wa] <= key_reg;
            val_mem[ent_wa] <= value_reg;
        end
        key_q <= key_mem[ent_ra];
        val_q <= val_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        link_q <= link_mem[ent_ra];
    end

    // bin heads
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_q <= head_mem[head_ra];
    end

    `include "chained_hash_table_engine_assert.svh"

    `CHT_ASSERT_ALWAYS(a_slots_bound, slots_used_reg <= NO_SLOT)
    `CHT_ASSERT_NEXT(a_bins_grow_only, 1'b1, bins_reg >= $past(bins_reg))
    `CHT_ASSERT_ALWAYS(a_rebuild_in_range,
        (state_reg != S_RB_LINK) || (rb_slot_reg < slots_used_reg))

endmodule

### tb/chained_hash_table_monitor.sv
// Channel monitor for the chained hash table engine: predicts each result word and checks it.
module chained_hash_table_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        hit,
    input  logic [31:0] read_value,
    output int          fail_count,
    output int          pending,
    output int          words_checked,
    output int          hits_seen,
    output int          full_seen
);
    import cht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SLOTS = 256;
    localparam int NO_SLOT    = 256;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [31:0] read_value;
    } table_outcome_t;

    logic [31:0]    slot_key [POOL_SLOTS];
    logic [31:0]    slot_val [POOL_SLOTS];
    int             slot_link [POOL_SLOTS];
    bit             slot_live [POOL_SLOTS];
    int             bin_head [POOL_SLOTS];
    int             used_slots;
    int             bin_total;
    table_outcome_t outcome_q [$];

    function automatic void relink_all_bins();
        int b;
        for (int i = 0; i < POOL_SLOTS; i++)
            bin_head[i] = NO_SLOT;
        for (int s = 0; s < used_slots; s++)
        begin
            if (slot_live[s])
            begin
                b = int'(slot_key[s] % 32'(bin_total));
                slot_link[s] = bin_head[b];
                bin_head[b] = s;
            end
        end
    endfunction

    function automatic table_outcome_t predict_request(logic [1:0] rt, logic [31:0] k,
                                                       logic [31:0] v);
        table_outcome_t o;
        int b;
        int cur;
        int prev;
        o = '{status: ST_DONE, hit: 1'b0, read_value: 32'd0};
        b = int'(k % 32'(bin_total));
        if (rt == REQ_GET)
        begin
            o.status = ST_MISS;
            cur = bin_head[b];
            while (cur != NO_SLOT)
            begin
                if (slot_key[cur] == k)
                begin
                    o.status = ST_DONE;
                    o.hit = 1'b1;
                    o.read_value = slot_val[cur];
                    break;
                end
                cur = slot_link[cur];
            end
        end
        else if (rt == REQ_SET)
        begin
            if (used_slots >= POOL_SLOTS)
                o.status = ST_FULL;
            else
            begin
                if (used_slots >= bin_total && bin_total < POOL_SLOTS)
                begin
                    bin_total = bin_total * 2;
                    relink_all_bins();
                    b = int'(k % 32'(bin_total));
                end
                slot_key[used_slots] = k;
                slot_val[used_slots] = v;
                slot_live[used_slots] = 1'b1;
                slot_link[used_slots] = bin_head[b];
                bin_head[b] = used_slots;
                used_slots++;
            end
        end
        else if (rt == REQ_DEL)
        begin
            o.status = ST_MISS;
            prev = NO_SLOT;
            cur = bin_head[b];
            while (cur != NO_SLOT)
            begin
                if (slot_key[cur] == k)
                begin
                    if (prev != NO_SLOT)
                        slot_link[prev] = slot_link[cur];
                    else
                        bin_head[b] = slot_link[cur];
                    slot_link[cur] = NO_SLOT;
                    slot_live[cur] = 1'b0;
                    o.status = ST_DONE;
                    break;
                end
                prev = cur;
                cur = slot_link[cur];
            end
        end
        return o;
    endfunction

    always @(posedge clk)
    begin
        table_outcome_t exp_w;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                slot_key[i] = '0;
                slot_val[i] = '0;
                slot_link[i] = NO_SLOT;
                slot_live[i] = 1'b0;
                bin_head[i] = NO_SLOT;
            end
            outcome_q.delete();
            used_slots = 0;
            bin_total = 8;
            fail_count = 0;
            pending = 0;
            words_checked = 0;
            hits_seen = 0;
            full_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                outcome_q.push_back(predict_request(req_type, key, value));
            if (out_valid && !out_stall)
            begin
                words_checked++;
                if (outcome_q.size() == 0)
                begin
                    $error("result word with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_w = outcome_q.pop_front();
                    if (status !== exp_w.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.status, status);
                        fail_count++;
                    end
                    if (hit !== exp_w.hit)
                    begin
                        $error("hit: expected %0d, got %0d", exp_w.hit, hit);
                        fail_count++;
                    end
                    if (read_value !== exp_w.read_value)
                    begin
                        $error("read_value: expected %h, got %h", exp_w.read_value,
                               read_value);
                        fail_count++;
                    end
                    if (exp_w.hit)
                        hits_seen++;
                    if (exp_w.status == ST_FULL)
                        full_seen++;
                end
            end
            pending = outcome_q.size();
        end
    end
endmodule

### tb/tb_chained_hash_table_engine.sv
// Testbench top for the chained hash table engine: stimulus, stall patterns and verdict.
module tb_chained_hash_table_engine;
    import cht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_GET;
    logic [31:0] key = '0;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        hit;
    logic [31:0] read_value;

    int          fail_count;
    int          pending;
    int          words_checked;
    int          hits_seen;
    int          full_seen;
    int          send_idle = 16;
    int          recv_idle = 54;
    logic [31:0] key_pool [24];

    chained_hash_table_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .key(key), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit(hit), .read_value(read_value)
    );

    chained_hash_table_monitor mon (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .key(key), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit(hit), .read_value(read_value),
        .fail_count(fail_count), .pending(pending), .words_checked(words_checked),
        .hits_seen(hits_seen), .full_seen(full_seen)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // entered and left at a falling edge
    task automatic send_word(logic [1:0] rt, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req_type <= rt;
        key <= k;
        value <= v;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_random_word();
        int          pick;
        logic [1:0]  rt;
        logic [31:0] k;
        pick = $urandom_range(99);
        if (pick < 40)
            rt = REQ_SET;
        else if (pick < 75)
            rt = REQ_GET;
        else if (pick < 95)
            rt = REQ_DEL;
        else
            rt = REQ_NOP;
        if ($urandom_range(99) < 65)
            k = key_pool[$urandom_range(23)];
        else
            k = $urandom;
        send_word(rt, k, $urandom);
    endtask

    initial
    begin
        for (int i = 0; i < 24; i++)
        begin
            if (i % 3 == 0)
                key_pool[i] = $urandom;
            else
                key_pool[i] = key_pool[i-1] + (32'd1 << $urandom_range(3, 31));
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, unused code, extremes, duplicates, delete of newest
        send_word(REQ_GET, 32'd0, 32'd0);
        send_word(REQ_DEL, 32'hFFFF_FFFF, 32'd0);
        send_word(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_SET, 32'd0, 32'd0);
        send_word(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_GET, 32'd0, 32'hFFFF_FFFF);
        send_word(REQ_GET, 32'hFFFF_FFFF, 32'd0);
        send_word(REQ_SET, 32'd5, 32'hAAAA_5555);
        send_word(REQ_SET, 32'd13, 32'h1234_5678);
        send_word(REQ_SET, 32'd5, 32'h5555_AAAA);
        send_word(REQ_GET, 32'd5, 32'd0);
        send_word(REQ_DEL, 32'd5, 32'd0);
        send_word(REQ_GET, 32'd5, 32'd0);
        send_word(REQ_GET, 32'd13, 32'd0);
        send_word(REQ_DEL, 32'd21, 32'd0);
        send_word(REQ_DEL, 32'd5, 32'd0);
        send_word(REQ_GET, 32'd5, 32'd0);
        send_word(REQ_SET, 32'd5, 32'h0F0F_0F0F);
        send_word(REQ_GET, 32'd5, 32'd0);
        send_word(REQ_DEL, 32'd0, 32'd0);
        send_word(REQ_GET, 32'd0, 32'd0);

        for (int i = 0; i < 270; i++)
            send_random_word();
        send_idle = 54;
        recv_idle = 16;
        for (int i = 0; i < 270; i++)
            send_random_word();
        send_idle = 0;
        recv_idle = 0;
        for (int i = 0; i < 270; i++)
            send_random_word();
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d result words: %0d get hits, %0d refused for a full pool",
                 words_checked, hits_seen, full_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
